FILE: rtl/bes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bes_pkg: shared types and codes for the bipartite edge swap engine
// Holds the input modes, result status codes, register indexes, fixed field
// widths and the sequencer state type.
// ----------------------------------------------------------------------------
package bes_pkg;

    // Fixed field widths
    localparam int unsigned IDX_W  = 12;
    localparam int unsigned NODE_W = 10;
    localparam int unsigned PICK_W = 16;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned ATT_W  = 17;
    localparam int unsigned EC_W   = 13;
    localparam int unsigned CFG_W  = 16;

    // Input modes
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_ATTEMPT = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;

    // Result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOPART  = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_EDGE_COUNT   = 2'd0;
    localparam logic [1:0] REG_TARGET_SWAPS = 2'd1;
    localparam logic [1:0] REG_EXTRA_TRIES  = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_HEAD,
        S_MARK,
        S_COUNT,
        S_MOD,
        S_SEL,
        S_SW1,
        S_SW2,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/bipartite_edge_swap.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bipartite_edge_swap: degree-preserving edge swap on a stored edge list
// Edge list and node marks sit in synchronous RAMs; a sequencer scans them.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                    | payload
//  in      | input     | i_in_valid / o_in_stall      | mode, index, left, right, pick
//  out     | output    | o_out_valid / i_out_stall    | left, right, status, partner, count
//  cfg     | input     | i_cfg_we                     | i_cfg_index, i_cfg_data
//
//  Load, read, refused and out-of-range attempts need no scan of the edge RAM.
//  An attempt that finds a partner runs three scans of the edge RAM over the edges
//  in use, 16 remainder steps and a mark-clearing sweep.
//  After reset every entry of the mark RAMs is cleared before any transfer.
//  One item at a time; the next is taken while a result waits in the output register.
// ----------------------------------------------------------------------------
module bipartite_edge_swap #(
    parameter int unsigned MAX_EDGES = 4096,
    parameter int unsigned MAX_NODES = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [1:0]                 i_mode,
    input  wire logic [bes_pkg::IDX_W-1:0]  i_edge_index,
    input  wire logic [bes_pkg::NODE_W-1:0] i_left_in,
    input  wire logic [bes_pkg::NODE_W-1:0] i_right_in,
    input  wire logic [bes_pkg::PICK_W-1:0] i_pick,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic      [bes_pkg::NODE_W-1:0] o_left_out,
    output logic      [bes_pkg::NODE_W-1:0] o_right_out,
    output logic      [1:0]                 o_status,
    output logic      [bes_pkg::IDX_W-1:0]  o_partner_edge,
    output logic      [bes_pkg::CNT_W-1:0]  o_success_count,
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_index,
    input  wire logic [bes_pkg::CFG_W-1:0]  i_cfg_data
);
    import bes_pkg::*;

    localparam int unsigned EW = $clog2(MAX_EDGES);
    localparam int unsigned NW = $clog2(MAX_NODES);
    localparam int unsigned KW = $clog2(MAX_EDGES + 1);

    // Control registers
    t_state            r_state, n_state;
    logic              r_v1, n_v1, r_v2, n_v2;
    logic              r_pend, n_pend;
    logic              r_found, n_found;
    logic [KW-1:0]     r_k, n_k;
    logic [NW-1:0]     r_clr, n_clr;
    logic [CNT_W-1:0]  r_succ, n_succ;
    logic [ATT_W-1:0]  r_att, n_att;
    logic [EC_W-1:0]   r_edge_count;
    logic [CNT_W-1:0]  r_target, r_extra;
    logic              r_o_valid, n_o_valid;
    logic              w_mod_start;

    // Payload registers
    logic [EW-1:0]     r_e1, n_e1, r_k1, n_k1, r_k2, n_k2, r_pk, n_pk;
    logic [NODE_W-1:0] r_a, n_a, r_b, n_b, r_l2, n_l2, r_r2, n_r2, r_pl, n_pl;
    logic [PICK_W-1:0] r_pick, n_pick;
    logic [KW-1:0]     r_avail, n_avail, r_sel, n_sel;
    logic              r_rd_ok, n_rd_ok;
    logic [1:0]        r_status, n_status;
    logic [IDX_W-1:0]  r_partner, n_partner;
    logic [NODE_W-1:0] r_lo, n_lo, r_ro, n_ro;
    logic [NODE_W-1:0] r_o_left, n_o_left, r_o_right, n_o_right;
    logic [1:0]        r_o_status, n_o_status;
    logic [IDX_W-1:0]  r_o_partner, n_o_partner;
    logic [CNT_W-1:0]  r_o_succ, n_o_succ;

    // Memory ports
    logic              w_l_we, w_r_we, w_lm_we, w_rm_we, w_lm_wd, w_rm_wd;
    logic [EW-1:0]     w_l_waddr, w_e_raddr;
    logic [NODE_W-1:0] w_l_wdata, w_el, w_er;
    logic [NW-1:0]     w_lm_waddr, w_rm_waddr;
    logic              w_lm, w_rm;

    // Derived values
    logic [KW-1:0]     w_n;
    logic              w_idx_ok, w_e1_in, w_acc, w_issue, w_drain, w_forb;
    logic              w_el_ok, w_er_ok, w_l2_ok, w_r2_ok;
    logic [ATT_W-1:0]  w_limit;
    logic              w_mod_done;
    logic [KW-1:0]     w_rem;

    assign w_n      = ({19'd0, r_edge_count} < 32'(MAX_EDGES)) ? KW'(r_edge_count)
                                                               : KW'(MAX_EDGES);
    assign w_idx_ok = {20'd0, i_edge_index} < 32'(MAX_EDGES);
    assign w_e1_in  = {20'd0, i_edge_index} < 32'(w_n);
    assign w_limit  = {1'b0, r_target} + {1'b0, r_extra};
    assign w_acc    = i_in_valid && (r_state == S_IDLE);
    assign w_issue  = r_k < w_n;
    assign w_drain  = !w_issue && !r_v1 && !r_v2;
    assign w_el_ok  = {22'd0, w_el} < 32'(MAX_NODES);
    assign w_er_ok  = {22'd0, w_er} < 32'(MAX_NODES);
    assign w_l2_ok  = {22'd0, r_l2} < 32'(MAX_NODES);
    assign w_r2_ok  = {22'd0, r_r2} < 32'(MAX_NODES);
    assign w_forb   = (w_l2_ok && w_lm) || (w_r2_ok && w_rm);

    // Edge and mark memories
    bes_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_left_store (
        .i_clk(i_clk), .i_we(w_l_we), .i_waddr(w_l_waddr), .i_wdata(w_l_wdata),
        .i_raddr(w_e_raddr), .o_rdata(w_el)
    );
    bes_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_right_store (
        .i_clk(i_clk), .i_we(w_r_we), .i_waddr(EW'(i_edge_index)), .i_wdata(i_right_in),
        .i_raddr(w_e_raddr), .o_rdata(w_er)
    );
    bes_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_left_mark (
        .i_clk(i_clk), .i_we(w_lm_we), .i_waddr(w_lm_waddr), .i_wdata(w_lm_wd),
        .i_raddr(NW'(w_el)), .o_rdata(w_lm)
    );
    bes_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_right_mark (
        .i_clk(i_clk), .i_we(w_rm_we), .i_waddr(w_rm_waddr), .i_wdata(w_rm_wd),
        .i_raddr(NW'(w_er)), .o_rdata(w_rm)
    );

    // Partner selection remainder
    bes_mod #(.DIV_W(KW)) u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mod_start),
        .i_dividend(r_pick), .i_divisor(r_avail), .o_done(w_mod_done), .o_rem(w_rem)
    );

    // Sequencer: next state, memory control and result capture
    always_comb begin
        n_state = r_state;   n_v1 = 1'b0;          n_v2 = 1'b0;
        n_pend = r_pend;     n_found = r_found;    n_k = r_k;
        n_clr = r_clr;       n_succ = r_succ;      n_att = r_att;
        n_e1 = r_e1;         n_k1 = r_k1;          n_k2 = r_k2;
        n_pk = r_pk;         n_a = r_a;            n_b = r_b;
        n_l2 = r_l2;         n_r2 = r_r2;          n_pl = r_pl;
        n_pick = r_pick;     n_avail = r_avail;    n_sel = r_sel;
        n_rd_ok = r_rd_ok;   n_status = r_status;  n_partner = r_partner;
        n_lo = r_lo;         n_ro = r_ro;
        n_o_valid = r_o_valid && i_out_stall;
        n_o_left = r_o_left; n_o_right = r_o_right; n_o_status = r_o_status;
        n_o_partner = r_o_partner; n_o_succ = r_o_succ;
        w_mod_start = 1'b0;
        w_l_we = 1'b0;       w_r_we = 1'b0;
        w_l_waddr = EW'(i_edge_index);
        w_l_wdata = i_left_in;
        w_e_raddr = EW'(i_edge_index);
        w_lm_we = 1'b0;      w_rm_we = 1'b0;
        w_lm_wd = 1'b1;      w_rm_wd = 1'b1;
        w_lm_waddr = NW'(w_el);
        w_rm_waddr = NW'(w_er);

        // Scan pipeline: issue edge reads, then stage the node ids
        if (r_state == S_MARK || r_state == S_COUNT || r_state == S_SEL) begin
            w_e_raddr = EW'(r_k);
            n_v1 = w_issue;
            n_k1 = EW'(r_k);
            if (w_issue) begin
                n_k = r_k + 1'b1;
            end
            n_v2 = r_v1;
            n_k2 = r_k1;
            n_l2 = w_el;
            n_r2 = w_er;
        end

        unique case (r_state)
            S_CLEAR: begin
                w_lm_we = 1'b1;  w_rm_we = 1'b1;
                w_lm_wd = 1'b0;  w_rm_wd = 1'b0;
                w_lm_waddr = r_clr;
                w_rm_waddr = r_clr;
                if (r_clr == NW'(MAX_NODES - 1)) begin
                    n_state = r_pend ? S_DONE : S_IDLE;
                    n_pend  = 1'b0;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    n_status = ST_OK;  n_partner = '0;
                    n_lo = '0;         n_ro = '0;
                    n_state = S_DONE;
                    case (i_mode)
                        MODE_LOAD: begin
                            w_l_we = w_idx_ok;
                            w_r_we = w_idx_ok;
                        end
                        MODE_ATTEMPT: begin
                            if (r_succ >= r_target || r_att >= w_limit) begin
                                n_status = ST_REFUSED;
                            end else begin
                                n_att = r_att + 1'b1;
                                if (!w_e1_in) begin
                                    n_status = ST_NOPART;
                                end else begin
                                    n_e1 = EW'(i_edge_index);
                                    n_pick = i_pick;
                                    n_state = S_HEAD;
                                end
                            end
                        end
                        MODE_READ: begin
                            n_rd_ok = w_idx_ok;
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_lo = r_rd_ok ? w_el : '0;
                n_ro = r_rd_ok ? w_er : '0;
                n_state = S_DONE;
            end
            S_HEAD: begin
                n_a = w_el;
                n_b = w_er;
                n_k = '0;
                n_state = S_MARK;
            end
            S_MARK: begin
                // Mark left nodes sharing b, right nodes sharing a
                w_lm_we = r_v1 && (w_er == r_b) && w_el_ok;
                w_rm_we = r_v1 && (w_el == r_a) && w_er_ok;
                if (w_drain) begin
                    n_k = '0;
                    n_avail = '0;
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                if (r_v2 && !w_forb) begin
                    n_avail = r_avail + 1'b1;
                end
                if (w_drain) begin
                    if (r_avail == '0) begin
                        n_status = ST_NOPART;
                        n_pend = 1'b1;
                        n_clr = '0;
                        n_state = S_CLEAR;
                    end else begin
                        w_mod_start = 1'b1;
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (w_mod_done) begin
                    n_sel = w_rem;
                    n_found = 1'b0;
                    n_k = '0;
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                if (r_v2 && !w_forb && !r_found) begin
                    if (r_sel == '0) begin
                        n_found = 1'b1;
                        n_pk = r_k2;
                        n_pl = r_l2;
                    end else begin
                        n_sel = r_sel - 1'b1;
                    end
                end
                if (w_drain) begin
                    n_state = S_SW1;
                end
            end
            S_SW1: begin
                w_l_we = 1'b1;
                w_l_waddr = r_e1;
                w_l_wdata = r_pl;
                n_state = S_SW2;
            end
            S_SW2: begin
                w_l_we = 1'b1;
                w_l_waddr = r_pk;
                w_l_wdata = r_a;
                n_succ = r_succ + 1'b1;
                n_status = ST_OK;
                n_partner = IDX_W'(r_pk);
                n_pend = 1'b1;
                n_clr = '0;
                n_state = S_CLEAR;
            end
            S_DONE: begin
                // Hand over once the output register is free
                if (!r_o_valid || !i_out_stall) begin
                    n_o_valid = 1'b1;
                    n_o_left = r_lo;
                    n_o_right = r_ro;
                    n_o_status = r_status;
                    n_o_partner = r_partner;
                    n_o_succ = r_succ;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;      r_v2 <= 1'b0;
            r_pend <= 1'b0;    r_found <= 1'b0;
            r_k <= '0;         r_clr <= '0;
            r_succ <= '0;      r_att <= '0;
            r_o_valid <= 1'b0;
            r_edge_count <= EC_W'(1);
            r_target <= '0;    r_extra <= '0;
        end else begin
            r_v1 <= n_v1;      r_v2 <= n_v2;
            r_pend <= n_pend;  r_found <= n_found;
            r_k <= n_k;        r_clr <= n_clr;
            r_succ <= n_succ;  r_att <= n_att;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_EDGE_COUNT:   r_edge_count <= i_cfg_data[EC_W-1:0];
                    REG_TARGET_SWAPS: r_target <= i_cfg_data;
                    REG_EXTRA_TRIES:  r_extra <= i_cfg_data;
                    default: begin
                        r_target <= r_target;
                    end
                endcase
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_e1 <= n_e1;        r_k1 <= n_k1;        r_k2 <= n_k2;
        r_pk <= n_pk;        r_a <= n_a;          r_b <= n_b;
        r_l2 <= n_l2;        r_r2 <= n_r2;        r_pl <= n_pl;
        r_pick <= n_pick;    r_avail <= n_avail;  r_sel <= n_sel;
        r_rd_ok <= n_rd_ok;  r_status <= n_status; r_partner <= n_partner;
        r_lo <= n_lo;        r_ro <= n_ro;
        r_o_left <= n_o_left;       r_o_right <= n_o_right;
        r_o_status <= n_o_status;   r_o_partner <= n_o_partner;
        r_o_succ <= n_o_succ;
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_o_valid;
    assign o_left_out      = r_o_left;
    assign o_right_out     = r_o_right;
    assign o_status        = r_o_status;
    assign o_partner_edge  = r_o_partner;
    assign o_success_count = r_o_succ;

endmodule

`default_nettype wire

FILE: rtl/bes_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bes_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bes_ram #(
    parameter int unsigned WIDTH = 10,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/bes_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bes_mod: iterative remainder unit
// Restoring remainder of a 16-bit dividend by a divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module bes_mod #(
    parameter int unsigned DIV_W = 13
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [bes_pkg::PICK_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0]           i_divisor,
    output logic                            o_done,
    output logic      [DIV_W-1:0]           o_rem
);
    import bes_pkg::*;

    localparam int unsigned STEP_W = $clog2(PICK_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W:0]    r_rem;
    logic [PICK_W-1:0] r_q;
    logic [DIV_W:0]    w_trial;

    // Shift in the next dividend bit and subtract where it fits
    always_comb begin
        w_trial = {r_rem[DIV_W-1:0], r_q[PICK_W-1]};
        if (w_trial >= {1'b0, i_divisor}) begin
            w_trial = w_trial - {1'b0, i_divisor};
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(PICK_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_trial;
            r_q   <= {r_q[PICK_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[DIV_W-1:0];

endmodule

`default_nettype wire

FILE: test/bes_checker.sv
// ----------------------------------------------------------------------------
// bes_checker: result predictor and scoreboard for bipartite_edge_swap
// Watches the input, output and register channels, keeps its own copy of the
// edge list, counters and registers, predicts one result per input transfer
// and compares each output transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bes_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_in_stall,
    input  wire logic [1:0]                 i_mode,
    input  wire logic [bes_pkg::IDX_W-1:0]  i_edge_index,
    input  wire logic [bes_pkg::NODE_W-1:0] i_left_in,
    input  wire logic [bes_pkg::NODE_W-1:0] i_right_in,
    input  wire logic [bes_pkg::PICK_W-1:0] i_pick,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_stall,
    input  wire logic [bes_pkg::NODE_W-1:0] i_left_out,
    input  wire logic [bes_pkg::NODE_W-1:0] i_right_out,
    input  wire logic [1:0]                 i_status,
    input  wire logic [bes_pkg::IDX_W-1:0]  i_partner_edge,
    input  wire logic [bes_pkg::CNT_W-1:0]  i_success_count,
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_index,
    input  wire logic [bes_pkg::CFG_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import bes_pkg::*;

    localparam int unsigned EDGE_DEPTH = 4096;
    localparam int unsigned NODE_DEPTH = 1024;

    typedef struct packed {
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
        logic [1:0]        status;
        logic [IDX_W-1:0]  partner;
        logic [CNT_W-1:0]  count;
    } t_swap_result;

    t_swap_result      expected_q[$];
    logic [NODE_W-1:0] left_mem  [0:EDGE_DEPTH-1];
    logic [NODE_W-1:0] right_mem [0:EDGE_DEPTH-1];
    bit                left_seen [0:NODE_DEPTH-1];
    bit                right_seen[0:NODE_DEPTH-1];
    logic [CNT_W-1:0]  swaps_done;
    logic [ATT_W-1:0]  tries_done;
    logic [EC_W-1:0]   edges_used;
    logic [CFG_W-1:0]  swap_target;
    logic [CFG_W-1:0]  spare_tries;
    int                fails = 0;

    assign o_fail_count = fails;

    task automatic report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fails++;
    endtask

    function automatic bit is_blocked(int k);
        return left_seen[left_mem[k]] || right_seen[right_mem[k]];
    endfunction

    // Mark, count, select and exchange left nodes; returns the status
    function automatic logic [1:0] try_swap(int first, int pick, output int partner);
        int         n;
        int         avail;
        int         sel;
        int         k;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        logic [1:0] st;
        partner = 0;
        st = ST_NOPART;
        n = (edges_used > EDGE_DEPTH) ? EDGE_DEPTH : int'(edges_used);
        tries_done = tries_done + 1'b1;
        if (first >= n)
            return ST_NOPART;
        a = left_mem[first];
        b = right_mem[first];
        for (k = 0; k < n; k++) begin
            if (right_mem[k] == b)
                left_seen[left_mem[k]] = 1'b1;
            if (left_mem[k] == a)
                right_seen[right_mem[k]] = 1'b1;
        end
        avail = 0;
        for (k = 0; k < n; k++)
            if (!is_blocked(k))
                avail++;
        if (avail != 0) begin
            sel = pick % avail;
            for (k = 0; k < n; k++) begin
                if (!is_blocked(k)) begin
                    if (sel == 0)
                        break;
                    sel--;
                end
            end
            left_mem[first] = left_mem[k];
            left_mem[k] = a;
            swaps_done = swaps_done + 1'b1;
            partner = k;
            st = ST_OK;
        end
        foreach (left_seen[j]) begin
            left_seen[j]  = 1'b0;
            right_seen[j] = 1'b0;
        end
        return st;
    endfunction

    function automatic t_swap_result predict_result(logic [1:0] mode, int idx,
                                                    logic [NODE_W-1:0] lin,
                                                    logic [NODE_W-1:0] rin, int pick);
        t_swap_result r;
        int           part;
        r = '0;
        case (mode)
            MODE_LOAD: begin
                left_mem[idx]  = lin;
                right_mem[idx] = rin;
            end
            MODE_ATTEMPT: begin
                if (swaps_done >= swap_target ||
                    int'(tries_done) >= int'(swap_target) + int'(spare_tries)) begin
                    r.status = ST_REFUSED;
                end else begin
                    r.status  = try_swap(idx, pick, part);
                    r.partner = part[IDX_W-1:0];
                end
            end
            MODE_READ: begin
                r.left  = left_mem[idx];
                r.right = right_mem[idx];
            end
            default: ;
        endcase
        r.count = swaps_done;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_swap_result want;
        if (!i_rst_n) begin
            swaps_done  = '0;
            tries_done  = '0;
            edges_used  = EC_W'(1);
            swap_target = '0;
            spare_tries = '0;
            expected_q.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_EDGE_COUNT:   edges_used  = i_cfg_data[EC_W-1:0];
                    REG_TARGET_SWAPS: swap_target = i_cfg_data;
                    REG_EXTRA_TRIES:  spare_tries = i_cfg_data;
                    default: ;
                endcase
            end
            // compare the output transfer with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    report("result transfer with nothing expected");
                end else begin
                    want = expected_q.pop_front();
                    if (i_left_out != want.left)
                        report($sformatf("left_out exp %0d got %0d", want.left, i_left_out));
                    if (i_right_out != want.right)
                        report($sformatf("right_out exp %0d got %0d", want.right, i_right_out));
                    if (i_status != want.status)
                        report($sformatf("status exp %0d got %0d", want.status, i_status));
                    if (i_partner_edge != want.partner)
                        report($sformatf("partner_edge exp %0d got %0d",
                                         want.partner, i_partner_edge));
                    if (i_success_count != want.count)
                        report($sformatf("success_count exp %0d got %0d",
                                         want.count, i_success_count));
                end
            end
            // predict for the input transfer and queue it at the tail
            if (i_in_valid && !i_in_stall) begin
                want = predict_result(i_mode, int'(i_edge_index),
                                      i_left_in, i_right_in, int'(i_pick));
                expected_q.insert(expected_q.size(), want);
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

FILE: test/tb_bipartite_edge_swap.sv
// ----------------------------------------------------------------------------
// tb_bipartite_edge_swap: regression bench for the edge swap engine
// Loads the low edges and the top entry of the store, runs directed cases for
// refusal, out-of-range first edges, no available partner and the unused mode,
// then random phases over several register settings with bursty input and a
// stalling receiver.
// ----------------------------------------------------------------------------
module tb_bipartite_edge_swap;
    import bes_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned EDGE_DEPTH = 4096;
    localparam int unsigned FILL_EDGES = 16;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_mode;
    logic [IDX_W-1:0]  i_edge_index;
    logic [NODE_W-1:0] i_left_in;
    logic [NODE_W-1:0] i_right_in;
    logic [PICK_W-1:0] i_pick;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [NODE_W-1:0] o_left_out;
    logic [NODE_W-1:0] o_right_out;
    logic [1:0]        o_status;
    logic [IDX_W-1:0]  o_partner_edge;
    logic [CNT_W-1:0]  o_success_count;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;
    int                fail_count;
    int                pending;
    int                burst_left;
    int                stall_style = 0;
    int                stall_left = 0;

    bipartite_edge_swap u_top (.*);

    bes_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_mode(i_mode), .i_edge_index(i_edge_index), .i_left_in(i_left_in),
        .i_right_in(i_right_in), .i_pick(i_pick),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_left_out(o_left_out), .i_right_out(o_right_out), .i_status(o_status),
        .i_partner_edge(o_partner_edge), .i_success_count(o_success_count),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Receiver: switch between no stall, light and heavy stall
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 2);
            stall_left  = $urandom_range(8, 80);
        end
        stall_left--;
        case (stall_style)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 9) < 3);
            default: i_out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    // Mostly a small pool so that marks collide, sometimes any nonzero id
    function automatic logic [NODE_W-1:0] node_id();
        if ($urandom_range(0, 9) == 0)
            return NODE_W'($urandom_range(1, 1023));
        return NODE_W'($urandom_range(1, 4));
    endfunction

    // Present one item and hold it until the transfer
    task automatic send(logic [1:0] mode, int idx, int lin, int rin, int pick);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_edge_index <= IDX_W'(idx);
        i_left_in    <= NODE_W'(lin);
        i_right_in   <= NODE_W'(rin);
        i_pick       <= PICK_W'(pick);
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and wait until every expected result has arrived
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Reads and loads stay on loaded edges; out-of-range attempts read nothing
    task automatic random_item(int edges);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            send(MODE_ATTEMPT, $urandom_range(0, edges - 1), node_id(), node_id(),
                 $urandom_range(0, 65535));
        else if (roll < 66)
            send(MODE_ATTEMPT, $urandom_range(edges, 4095), node_id(), node_id(),
                 $urandom_range(0, 65535));
        else if (roll < 84)
            send(MODE_READ, $urandom_range(0, edges - 1), node_id(), node_id(),
                 $urandom_range(0, 65535));
        else if (roll < 97)
            send(MODE_LOAD, $urandom_range(0, edges - 1), node_id(), node_id(),
                 $urandom_range(0, 65535));
        else
            send(MODE_UNUSED, $urandom_range(0, 4095), node_id(), node_id(),
                 $urandom_range(0, 65535));
    endtask

    // Run limit
    initial begin
        #36000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int edges;
        int count;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_mode       = MODE_LOAD;
        i_edge_index = '0;
        i_left_in    = '0;
        i_right_in   = '0;
        i_pick       = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = REG_EDGE_COUNT;
        i_cfg_data   = '0;
        burst_left   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // load every edge that is later read, plus the top entry of the store
        for (int e = 0; e < FILL_EDGES; e++)
            send(MODE_LOAD, e, node_id(), node_id(), $urandom_range(0, 65535));
        send(MODE_LOAD, EDGE_DEPTH - 1, 1023, 1023, 65535);

        // reset settings: target of zero refuses every attempt
        send(MODE_ATTEMPT, 0, 0, 0, 0);
        send(MODE_READ, 0, 0, 0, 0);
        send(MODE_READ, EDGE_DEPTH - 1, 0, 0, 0);
        send(MODE_UNUSED, 4095, 1023, 1023, 65535);
        drain();

        // single edge: the first edge marks itself and has no partner, then out of range
        write_reg(REG_TARGET_SWAPS, 65535);
        write_reg(REG_EXTRA_TRIES, 65535);
        send(MODE_ATTEMPT, 0, 0, 0, 0);
        send(MODE_ATTEMPT, 1, 0, 0, 7);
        send(MODE_ATTEMPT, 4095, 0, 0, 65535);
        drain();

        // eight identical edges leave no partner; one distinct edge is chosen
        write_reg(REG_EDGE_COUNT, 8);
        for (int e = 0; e < 8; e++)
            send(MODE_LOAD, e, 1, 1, 0);
        send(MODE_ATTEMPT, 3, 0, 0, 1);
        send(MODE_LOAD, 5, 2, 2, 0);
        send(MODE_ATTEMPT, 0, 0, 0, 65535);
        send(MODE_ATTEMPT, 7, 0, 0, 0);
        send(MODE_READ, 5, 0, 0, 0);
        send(MODE_READ, 0, 0, 0, 0);
        drain();

        // target already met: refused
        write_reg(REG_TARGET_SWAPS, 1);
        write_reg(REG_EXTRA_TRIES, 0);
        send(MODE_ATTEMPT, 2, 0, 0, 3);
        drain();

        // random phases over several settings, one at the largest loaded count
        for (int ph = 0; ph < 6; ph++) begin
            edges = (ph == 3) ? FILL_EDGES : $urandom_range(2, FILL_EDGES);
            count = 12;
            write_reg(REG_EDGE_COUNT, edges);
            write_reg(REG_TARGET_SWAPS, (ph == 5) ? $urandom_range(0, 40) : 65535);
            write_reg(REG_EXTRA_TRIES, (ph == 2) ? 0 : $urandom_range(0, 65535));
            for (int it = 0; it < count; it++)
                random_item(edges);
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
